>>> rtl/wesm_pkg.sv
// Shared widths, constants and handshake types of the wheel encoder speed meter.
// It depends on nothing else. The divider and the top level import it.
package wesm_pkg;

    // Field widths
    localparam int COUNT_W  = 6;
    localparam int DIST_W   = 40;
    localparam int TIME_W   = 64;
    localparam int SPEED_W  = 40;
    localparam int SLOT_W   = 16;
    localparam int WIN_W    = 6;
    localparam int CIRC_W   = 24;
    localparam int USPS_W   = 20;
    localparam int DVD_W    = CIRC_W + USPS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Default number of wheels
    localparam int DEF_NUM_WHEELS = 2;

    // Input event kinds carried in the mode field.
    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SLOT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CIRC = CFG_IDX_W'(2);

    // Arithmetic constants
    localparam logic [USPS_W-1:0]  US_PER_S  = USPS_W'(1000000);
    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};
    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    // Configuration reset values
    localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(9425);
    localparam logic [WIN_W-1:0]  WIN_RESET  = WIN_W'(20);
    localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(188500);

    // Request to the divider: start pulse and operands.
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    // Response from the divider: one-cycle done pulse and quotient.
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/wesm_divider.sv
// Restoring divider that retires one quotient bit per cycle.
// It depends on wesm_pkg for widths and the request and response types.
module wesm_divider
    import wesm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVD_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVD_W:0]    trial;
    logic              fits;

    // One step: shift in the next dividend bit and subtract when it fits.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        fits     = {{(TIME_W-DVD_W-1){1'b0}}, trial} >= dvs_reg;
        rem_next = fits ? DVD_W'(trial - dvs_reg[DVD_W:0]) : trial[DVD_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/wheel_encoder_speed_meter_core.sv
// Top level of the wheel encoder speed meter: sequencer, per-wheel state and output register.
// It depends on wesm_pkg and instantiates wesm_divider.
//
// Each transfer on the input stream is an encoder pulse or a timer tick for one wheel and
// yields one result transfer, except that a wheel index not below NUM_WHEELS is dropped.
// A tick or a pulse that does not close a window passes through the calculation and done
// states until its result is loaded into the output register; a pulse that closes a window
// with nonzero elapsed time also waits on the 44-step bit-serial divider that computes
// circumference_um * 1000000 / elapsed. The input is not ready while an item is in work,
// but the next item is accepted while a finished result still waits in the output register.
// Configuration writes are taken whenever cfg_wr_en is high and should be made while idle.
module wheel_encoder_speed_meter_core
    import wesm_pkg::*;
#(
    parameter int NUM_WHEELS = DEF_NUM_WHEELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // [63:0] now_us
    input  logic [1:0]            s_tuser,   // [0] mode, [1] wheel
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [151:0]          m_tdata,   // [5:0] pulse_count, [45:6] distance_um,
                                             // [109:46] elapsed_us, [149:110] speed_um_per_s,
                                             // [151:150] zero
    output logic [2:0]            m_tuser    // [0] wheel_out, [1] speed_valid, [2] speed_error
);

    localparam int IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Configuration registers
    logic [SLOT_W-1:0] slot_reg;
    logic [WIN_W-1:0]  win_reg;
    logic [CIRC_W-1:0] circ_reg;

    // Per-wheel state
    logic [COUNT_W-1:0] cnt_reg   [NUM_WHEELS];
    logic               run_reg   [NUM_WHEELS];
    logic [TIME_W-1:0]  start_reg [NUM_WHEELS];
    logic [TIME_W-1:0]  el_reg    [NUM_WHEELS];
    logic [DIST_W-1:0]  dist_reg  [NUM_WHEELS];

    // Sequencer and latched input
    logic [1:0]        state_reg, state_next;
    logic              mode_reg;
    logic              wheel_reg;
    logic [TIME_W-1:0] now_reg;

    // Result being assembled
    logic [COUNT_W-1:0] res_cnt_reg;
    logic [DIST_W-1:0]  res_dist_reg;
    logic [TIME_W-1:0]  res_el_reg;
    logic               res_valid_reg;
    logic [SPEED_W-1:0] res_speed_reg;
    logic               res_err_reg;

    // Output register
    logic               m_tvalid_reg;
    logic [151:0]       m_tdata_reg;
    logic [2:0]         m_tuser_reg;

    logic               wheel_ok;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] cnt_cur, count, cnt_next;
    logic               run_cur, run_next;
    logic [TIME_W-1:0]  start_cur, start_next;
    logic [TIME_W-1:0]  el_cur, el_next, since_start;
    logic [DIST_W-1:0]  dist_cur, dist_next;
    logic [DIST_W:0]    dist_sum;
    logic               close;
    logic               need_div;
    logic               out_load;
    logic [DVD_W-1:0]   product;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign wheel_ok = 32'(wheel_reg) < NUM_WHEELS;
    assign idx      = IDX_W'(wheel_reg);

    // Read the addressed wheel.
    assign cnt_cur   = cnt_reg[idx];
    assign run_cur   = run_reg[idx];
    assign start_cur = start_reg[idx];
    assign el_cur    = el_reg[idx];
    assign dist_cur  = dist_reg[idx];

    // Update of the addressed wheel for a pulse or a tick.
    always_comb
    begin
        dist_sum    = {1'b0, dist_cur} + (DIST_W+1)'(slot_reg);
        since_start = now_reg - start_cur;
        count       = cnt_cur;
        cnt_next    = cnt_cur;
        run_next    = run_cur;
        start_next  = start_cur;
        el_next     = el_cur;
        dist_next   = dist_cur;
        close       = 1'b0;
        if (mode_reg == MODE_PULSE)
        begin
            dist_next = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
            count     = cnt_cur + 1'b1;
            cnt_next  = count;
            if (count == COUNT_W'(1))
            begin
                if (!run_cur)
                begin
                    start_next = now_reg;
                    el_next    = '0;
                    run_next   = 1'b1;
                end
            end
            else if (count == win_reg)
            begin
                if (run_cur)
                begin
                    el_next  = since_start;
                    run_next = 1'b0;
                end
                else
                begin
                    el_next = '0;
                end
            end
            close = (count == win_reg);
            if (close)
            begin
                cnt_next = '0;
            end
        end
        else if (run_cur)
        begin
            el_next = since_start;
        end
        need_div = close && (el_next != '0);
    end

    // Dividend of the speed computation.
    assign product = DVD_W'(circ_reg) * DVD_W'(US_PER_S);

    assign div_req.start    = (state_reg == ST_CALC) && wheel_ok && need_div;
    assign div_req.dividend = product;
    assign div_req.divisor  = el_next;

    wesm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!wheel_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (need_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= SLOT_RESET;
            win_reg  <= WIN_RESET;
            circ_reg <= CIRC_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SLOT: slot_reg <= cfg_data[SLOT_W-1:0];
                REG_WIN:  win_reg  <= cfg_data[WIN_W-1:0];
                REG_CIRC: circ_reg <= cfg_data[CIRC_W-1:0];
                default:  ;
            endcase
        end
    end

    // Capture the input transfer.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            mode_reg  <= s_tuser[0];
            wheel_reg <= s_tuser[1];
            now_reg   <= s_tdata;
        end
    end

    // Per-wheel state write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                cnt_reg[i]   <= '0;
                run_reg[i]   <= 1'b0;
                start_reg[i] <= '0;
                el_reg[i]    <= '0;
                dist_reg[i]  <= '0;
            end
        end
        else if ((state_reg == ST_CALC) && wheel_ok)
        begin
            cnt_reg[idx]   <= cnt_next;
            run_reg[idx]   <= run_next;
            start_reg[idx] <= start_next;
            el_reg[idx]    <= el_next;
            dist_reg[idx]  <= dist_next;
        end
    end

    // Assemble the result; the speed arrives from the divider with saturation.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CALC)
        begin
            res_cnt_reg   <= count;
            res_dist_reg  <= dist_next;
            res_el_reg    <= el_next;
            res_valid_reg <= need_div;
            res_err_reg   <= close && (el_next == '0);
            res_speed_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_rsp.done)
        begin
            res_speed_reg <= (div_rsp.quotient[DVD_W-1:SPEED_W] != '0) ? SPEED_MAX
                                                                      : div_rsp.quotient[SPEED_W-1:0];
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= {2'b00, res_speed_reg, res_el_reg, res_dist_reg, res_cnt_reg};
            m_tuser_reg <= {res_err_reg, res_valid_reg, wheel_reg};
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sim/tb_wheel_encoder_speed_meter_core.sv
// Self-checking testbench for the wheel encoder speed meter core.
// Depends on wesm_pkg and wheel_encoder_speed_meter_core; predicts every result transfer
// from its own per-wheel model and compares each field as the result leaves the block.
`timescale 1ns / 1ps

module tb_wheel_encoder_speed_meter_core;
    import wesm_pkg::*;

    localparam int NUM_WHEELS  = DEF_NUM_WHEELS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_GAP    = 8;
    localparam int END_WAIT    = 100;
    localparam int PRINT_CAP   = 100;

    // Input event kinds.
    typedef enum logic {EV_PULSE = MODE_PULSE, EV_TICK = MODE_TICK} event_kind_t;

    typedef struct {
        event_kind_t       kind;
        logic              wheel;
        logic [TIME_W-1:0] now;
    } wheel_event_t;

    typedef struct packed {
        logic               wheel;
        logic [COUNT_W-1:0] count;
        logic [DIST_W-1:0]  distance;
        logic [TIME_W-1:0]  elapsed;
        logic               spd_valid;
        logic [SPEED_W-1:0] speed;
        logic               spd_err;
    } wheel_result_t;

    // Block ports.
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;   // [63:0] now_us
    logic [1:0]            s_tuser   = '0;   // [0] mode, [1] wheel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [151:0]          m_tdata;          // [5:0] pulse_count, [45:6] distance_um,
                                             // [109:46] elapsed_us, [149:110] speed_um_per_s
    logic [2:0]            m_tuser;          // [0] wheel_out, [1] speed_valid, [2] speed_error

    // Pending events, predicted results and run bookkeeping.
    wheel_event_t  event_q[$];
    wheel_result_t wheel_results_q[$];
    int            mismatch_cnt   = 0;
    int            cycle_cnt      = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    logic [TIME_W-1:0] stamp_us   = '0;

    // Predicted configuration, starting from the reset values.
    logic [SLOT_W-1:0] slot_um = SLOT_RESET;
    logic [WIN_W-1:0]  win_len = WIN_RESET;
    logic [CIRC_W-1:0] circ_um = CIRC_RESET;

    // Predicted per-wheel state.
    logic [COUNT_W-1:0] cnt_by_wheel     [NUM_WHEELS] = '{default: '0};
    logic               running_by_wheel [NUM_WHEELS] = '{default: 1'b0};
    logic [TIME_W-1:0]  start_by_wheel   [NUM_WHEELS] = '{default: '0};
    logic [TIME_W-1:0]  elapsed_by_wheel [NUM_WHEELS] = '{default: '0};
    logic [DIST_W-1:0]  dist_by_wheel    [NUM_WHEELS] = '{default: '0};

    wheel_encoder_speed_meter_core #(
        .NUM_WHEELS (NUM_WHEELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // Works out the result of one accepted event and advances the wheel state.
    function automatic void predict_wheel_event(input logic kind, input logic w,
                                                input logic [TIME_W-1:0] now);
        wheel_result_t     res;
        logic [DIST_W:0]   dist_sum;
        logic [TIME_W-1:0] quot;
        res = '0;
        res.wheel = w;
        if (kind == EV_PULSE)
        begin
            // Distance saturates at the top of its range.
            dist_sum = {1'b0, dist_by_wheel[w]} + (DIST_W+1)'(slot_um);
            dist_by_wheel[w] = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
            cnt_by_wheel[w] = cnt_by_wheel[w] + 1'b1;
            if (cnt_by_wheel[w] == COUNT_W'(1))
            begin
                // The first pulse of a window starts a stopped stopwatch only.
                if (!running_by_wheel[w])
                begin
                    start_by_wheel[w]   = now;
                    elapsed_by_wheel[w] = '0;
                    running_by_wheel[w] = 1'b1;
                end
            end
            else if (cnt_by_wheel[w] == win_len)
            begin
                if (running_by_wheel[w])
                begin
                    elapsed_by_wheel[w] = now - start_by_wheel[w];
                    running_by_wheel[w] = 1'b0;
                end
                else
                begin
                    elapsed_by_wheel[w] = '0;
                end
            end
            res.count = cnt_by_wheel[w];
            // Closing pulse: report speed, or flag a window of zero length in time.
            if (cnt_by_wheel[w] == win_len)
            begin
                if (elapsed_by_wheel[w] == '0)
                begin
                    res.spd_err = 1'b1;
                end
                else
                begin
                    quot = (TIME_W'(circ_um) * TIME_W'(US_PER_S)) / elapsed_by_wheel[w];
                    res.speed = (quot > TIME_W'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
                    res.spd_valid = 1'b1;
                end
                cnt_by_wheel[w] = '0;
            end
        end
        else
        begin
            if (running_by_wheel[w])
                elapsed_by_wheel[w] = now - start_by_wheel[w];
            res.count = cnt_by_wheel[w];
        end
        res.distance = dist_by_wheel[w];
        res.elapsed  = elapsed_by_wheel[w];
        wheel_results_q.push_back(res);
    endfunction

    // Event driver: presents queued events, idling at random, and predicts on each transfer.
    always @(posedge clk)
    begin : event_driver
        wheel_event_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_wheel_event(s_tuser[0], s_tuser[1], s_tdata);
            if (!s_tvalid || s_tready)
            begin
                if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.now;
                    s_tuser  <= {nxt.wheel, nxt.kind};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each result transfer against the oldest
    // prediction.
    always @(posedge clk)
    begin : result_monitor
        wheel_result_t want;
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (wheel_results_q.size() == 0)
            begin
                report_mismatch("result transfer with no event waiting for it");
            end
            else
            begin
                want = wheel_results_q.pop_front();
                check_field("wheel_out", 64'(m_tuser[0]), 64'(want.wheel));
                check_field("speed_valid", 64'(m_tuser[1]), 64'(want.spd_valid));
                check_field("speed_error", 64'(m_tuser[2]), 64'(want.spd_err));
                check_field("pulse_count", 64'(m_tdata[5:0]), 64'(want.count));
                check_field("distance_um", 64'(m_tdata[45:6]), 64'(want.distance));
                check_field("elapsed_us", m_tdata[109:46], want.elapsed);
                check_field("speed_um_per_s", 64'(m_tdata[149:110]), 64'(want.speed));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("tb_wheel_encoder_speed_meter_core: FAIL");
            $finish;
        end
    end

    function automatic void push_event(input event_kind_t kind, input logic w,
                                       input logic [TIME_W-1:0] now);
        wheel_event_t ev;
        ev.kind  = kind;
        ev.wheel = w;
        ev.now   = now;
        event_q.push_back(ev);
    endfunction

    // Mostly rising time with gaps of every size; now and then a repeat or a random jump.
    function automatic logic [TIME_W-1:0] next_stamp();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            stamp_us = {$urandom, $urandom};
        else if (r < 12)
            stamp_us = stamp_us;
        else if (r < 30)
            stamp_us = stamp_us + $urandom_range(1, 9);
        else
            stamp_us = stamp_us + $urandom_range(10, 50000);
        return stamp_us;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SLOT: slot_um = val[SLOT_W-1:0];
            REG_WIN:  win_len = val[WIN_W-1:0];
            REG_CIRC: circ_um = val[CIRC_W-1:0];
            default:  ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(input logic [SLOT_W-1:0] slot, input logic [WIN_W-1:0] win,
                              input logic [CIRC_W-1:0] circ);
        write_reg(REG_SLOT, CFG_DATA_W'(slot));
        write_reg(REG_WIN, CFG_DATA_W'(win));
        write_reg(REG_CIRC, CFG_DATA_W'(circ));
    endtask

    // Waits until every queued event went in and every predicted result came out.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (event_q.size() != 0 || s_tvalid || wheel_results_q.size() != 0);
        repeat (IDLE_GAP) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_random_phase(input int n_items);
        for (int k = 0; k < n_items; k++)
            push_event(($urandom_range(99) < 70) ? EV_PULSE : EV_TICK,
                       1'($urandom_range(1)), next_stamp());
        wait_idle();
    endtask

    // Stimulus: directed cases, then count wrap cases, then random phases.
    initial
    begin
        send_idle_pct  = 21;
        recv_stall_pct = 75;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: tick on a stopped wheel, start, tick at the top of time.
        push_event(EV_TICK, 1'b0, 64'd0);
        push_event(EV_PULSE, 1'b0, 64'd1000);
        push_event(EV_TICK, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        wait_idle();

        // Largest slot and circumference with a short window.
        set_config(16'hFFFF, 6'd3, 24'hFF_FFFF);
        // Very short window: speed saturates.
        push_event(EV_PULSE, 1'b0, 64'd1001);
        push_event(EV_PULSE, 1'b0, 64'd1004);
        // Time wraps through zero while the window is open.
        push_event(EV_PULSE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
        push_event(EV_TICK, 1'b1, 64'h8);
        push_event(EV_PULSE, 1'b1, 64'h10);
        push_event(EV_PULSE, 1'b1, 64'h20);
        // Window with no time passing gives the error flag.
        push_event(EV_PULSE, 1'b0, 64'd500);
        push_event(EV_PULSE, 1'b0, 64'd500);
        push_event(EV_PULSE, 1'b0, 64'd500);
        // Huge elapsed time: valid speed of zero.
        push_event(EV_PULSE, 1'b1, 64'd0);
        push_event(EV_PULSE, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        push_event(EV_PULSE, 1'b1, 64'h5555_5555_5555_5555);
        wait_idle();

        // Window of one pulse with zero slot and circumference; the stopwatch keeps running.
        set_config(16'd0, 6'd1, 24'd0);
        push_event(EV_PULSE, 1'b0, 64'd77);
        push_event(EV_TICK, 1'b0, 64'd90);
        push_event(EV_PULSE, 1'b0, 64'd95);
        push_event(EV_PULSE, 1'b1, 64'd3);
        wait_idle();

        // Count left above a shortened window wraps round, passing pulse one while running.
        set_config(16'd1234, 6'd6, 24'd188500);
        repeat (4) push_event(EV_PULSE, 1'b0, next_stamp());
        wait_idle();
        write_reg(REG_WIN, CFG_DATA_W'(2));
        for (int k = 0; k < 62; k++)
        begin
            push_event(EV_PULSE, 1'b0, next_stamp());
            if (k % 8 == 0)
                push_event(EV_TICK, 1'($urandom_range(1)), next_stamp());
        end
        wait_idle();

        // Window length zero closes when the count wraps to zero.
        write_reg(REG_WIN, CFG_DATA_W'(0));
        for (int k = 0; k < 64; k++)
        begin
            push_event(EV_PULSE, 1'b1, next_stamp());
            if (k % 8 == 3)
                push_event(EV_TICK, 1'($urandom_range(1)), next_stamp());
        end
        wait_idle();

        // Random phases under several settings and idling patterns.
        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
            begin
                send_idle_pct  = 75;
                recv_stall_pct = 21;
            end
            else if (p == 4)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (p)
                0:       set_config(16'd1, 6'd2, 24'd1);
                1:       set_config(16'hFFFF, 6'd63, 24'hFF_FFFF);
                2:       set_config(SLOT_RESET, WIN_RESET, CIRC_RESET);
                default: set_config(SLOT_W'($urandom_range(1, 65535)),
                                    WIN_W'($urandom_range(2, 8)),
                                    CIRC_W'($urandom_range(1, 24'hFF_FFFF)));
            endcase
            run_random_phase(170);
        end

        repeat (END_WAIT) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_wheel_encoder_speed_meter_core: PASS");
        else
            $display("tb_wheel_encoder_speed_meter_core: FAIL");
        $finish;
    end

endmodule
